@@ design/lruk_pkg.sv @@
// lru-k frame replacer: shared constants, codes and types
// no dependencies
`default_nettype none
package lruk_pkg;
  localparam int MaxFrames  = 64;
  localparam int MaxK       = 8;
  localparam int StampWidth = 48;
  localparam int FrameW     = $clog2(MaxFrames);
  localparam int CountW     = $clog2(MaxK + 1);
  localparam int KIdxW      = (MaxK > 1) ? $clog2(MaxK) : 1;
  localparam int TotalW     = 7;
  localparam int LimitW     = 7;
  localparam int DepthW     = 4;

  typedef logic [StampWidth-1:0] stamp_t;

  typedef enum logic [1:0] {
    ACT_ACCESS = 2'd0,
    ACT_SET    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_EVICT  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_PINNED  = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  localparam logic CFG_FRAMES = 1'b0;
  localparam logic CFG_DEPTH  = 1'b1;

  // request and result payloads
  typedef struct packed {
    action_t           action;
    logic [FrameW-1:0] frame;
    logic              make_evictable;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic [FrameW-1:0] victim_frame;
    logic [TotalW-1:0] evictable_count;
  } result_t;

  // command broadcast from control to every cell
  typedef struct packed {
    logic              access;
    logic              set_ev;
    logic              forget;
    logic              ev_value;
    logic [FrameW-1:0] frame;
    stamp_t            stamp;
  } cell_cmd_t;

  // per-cell view shifted along the chain
  typedef struct packed {
    logic   cand;
    logic   is_short;
    stamp_t key;
  } cell_view_t;
endpackage
`default_nettype wire

@@ design/lruk_if.sv @@
// valid/ready channel carrying one payload of type T
// depends on nothing
`default_nettype none
interface lruk_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/lru_k_frame_replacer_top.sv @@
// lru-k frame replacer top: request control, eviction scan, result register
// depends on lruk_pkg, lruk_if, lruk_frame_chain
//
// usage: requests (action, frame, make_evictable) arrive on req; one result
// (status, victim_frame, evictable_count) per request leaves on rsp.
// access, set and remove go through the exec state to a registered result.
// evict loads all frame views into a shift chain and scans them from the
// highest index to the lowest, one per cycle, before its result is registered.
// one request at a time; req is not ready until the result has been taken.
// a stalled receiver holds the result register and the block waits.
// reset (synchronous, active high) forgets every frame, clears the access
// clock and evictable count, and sets frames_in_use 64, history_depth 2.
// cfg writes take effect at the next edge; the user must make them only while idle (unchecked).
`default_nettype none
module lru_k_frame_replacer_top import lruk_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  lruk_if.sink           req,
  lruk_if.source         rsp,
  input wire logic       cfg_we,
  input wire logic       cfg_index,
  input wire logic [6:0] cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_EXEC = 4'b0010, S_SCAN = 4'b0100, S_OUT = 4'b1000
  } state_t;

  state_t             state;
  logic [LimitW-1:0]  frames_in_use;
  logic [DepthW-1:0]  history_depth;
  logic [KIdxW-1:0]   k_sel;
  action_t            act;
  logic [FrameW-1:0]  frame;
  logic               mk_ev;
  stamp_t             access_clock;
  logic [TotalW-1:0]  ev_total;
  logic [TotalW-1:0]  ev_total_next;
  status_t            exec_status;
  logic [FrameW:0]    scan_cnt;
  logic               have, best_short;
  stamp_t             best_key;
  logic [FrameW-1:0]  best;
  cell_cmd_t          cmd;
  cell_view_t         tail;
  logic [FrameW-1:0]  tail_index;
  logic               sel_ev, sel_trk, load, in_range, better;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= LimitW'(64);
      history_depth <= DepthW'(2);
    end else if (cfg_we) begin
      if (cfg_index == CFG_FRAMES) frames_in_use <= cfg_data;
      else                         history_depth <= cfg_data[DepthW-1:0];
    end
  end

  always_comb begin
    if (history_depth == '0) k_sel = '0;
    else if (history_depth > DepthW'(MaxK)) k_sel = KIdxW'(MaxK - 1);
    else k_sel = KIdxW'(history_depth - 1'b1);
  end

  assign in_range = ({1'b0, frame} < frames_in_use) ||
                    (frames_in_use > LimitW'(MaxFrames));

  always_comb begin
    cmd          = '0;
    cmd.frame    = (state == S_SCAN) ? best : frame;
    cmd.ev_value = mk_ev;
    cmd.stamp    = (access_clock == '1) ? access_clock : access_clock + 1'b1;
    if (state == S_EXEC) begin
      unique case (act)
        ACT_ACCESS: cmd.access = in_range;
        ACT_SET:    cmd.set_ev = in_range;
        ACT_REMOVE: cmd.forget = sel_trk && sel_ev;
        ACT_EVICT:  cmd.forget = 1'b0;
        default:    cmd.forget = 1'b0;
      endcase
    end else if (state == S_SCAN && scan_cnt == '0) begin
      cmd.forget = have;
    end
  end

  // status and evictable count of an access, set or remove
  always_comb begin
    exec_status   = ST_OK;
    ev_total_next = ev_total;
    unique case (act)
      ACT_ACCESS: begin
        if (!in_range) exec_status = ST_RANGE;
      end
      ACT_SET: begin
        if (!in_range) exec_status = ST_RANGE;
        else if (sel_trk && sel_ev != mk_ev)
          ev_total_next = mk_ev ? ev_total + 1'b1 : ev_total - 1'b1;
      end
      ACT_REMOVE: begin
        if (sel_trk && !sel_ev) exec_status = ST_PINNED;
        else if (sel_trk) ev_total_next = ev_total - 1'b1;
      end
      ACT_EVICT: exec_status = ST_OK;
      default:   exec_status = ST_OK;
    endcase
  end

  assign load = (state == S_EXEC) && (act == ACT_EVICT);

  // tail arrives in decreasing index order, so ties go to the later (lower) one
  assign better = tail.cand && (!have || (tail.is_short && !best_short) ||
                  (tail.is_short == best_short && tail.key <= best_key));

  lruk_frame_chain u_chain (
    .clk, .rst, .k_sel, .cmd, .load, .tail, .tail_index, .sel_ev, .sel_trk
  );

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      act   <= action_t'(req.data.action);
      frame <= req.data.frame;
      mk_ev <= req.data.make_evictable;
    end
    if (state == S_SCAN && scan_cnt != '0 && better) begin
      best_short <= tail.is_short;
      best_key   <= tail.key;
      best       <= tail_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      access_clock <= '0;
      ev_total     <= '0;
      scan_cnt     <= '0;
      have         <= 1'b0;
      rsp.data     <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (req.valid) state <= S_EXEC;
        S_EXEC: begin
          if (act == ACT_EVICT) begin
            scan_cnt <= (FrameW+1)'(MaxFrames);
            have     <= 1'b0;
            state    <= S_SCAN;
          end else begin
            rsp.data.status          <= exec_status;
            rsp.data.victim_frame    <= '0;
            rsp.data.evictable_count <= ev_total_next;
            ev_total                 <= ev_total_next;
            if (act == ACT_ACCESS && in_range) access_clock <= cmd.stamp;
            state                    <= S_OUT;
          end
        end
        S_SCAN: begin
          if (scan_cnt != '0) begin
            scan_cnt <= scan_cnt - 1'b1;
            if (better) have <= 1'b1;
          end else begin
            if (have) begin
              rsp.data.status          <= ST_OK;
              rsp.data.victim_frame    <= best;
              rsp.data.evictable_count <= ev_total - 1'b1;
              ev_total                 <= ev_total - 1'b1;
            end else begin
              rsp.data.status          <= ST_NONE;
              rsp.data.victim_frame    <= '0;
              rsp.data.evictable_count <= ev_total;
            end
            state <= S_OUT;
          end
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid)) else $error("request taken while result pending");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ev_total <= TotalW'(MaxFrames)) else $error("evictable count overflow");
  a_clock_mono: assert property (@(posedge clk) disable iff (rst)
    access_clock >= $past(access_clock)) else $error("access clock went back");
  a_victim_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.status != ST_OK |-> rsp.data.victim_frame == '0)
    else $error("victim set on failure");
endmodule
`default_nettype wire

@@ design/lruk_cell.sv @@
// one frame cell: flags, access count and MaxK stamps; exposes its eviction view
// depends on lruk_pkg
`default_nettype none
module lruk_cell import lruk_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [FrameW-1:0] index,
  input  wire logic [KIdxW-1:0]  k_sel,
  input  wire cell_cmd_t         cmd,
  output cell_view_t             view,
  output logic                   ev_flag,
  output logic                   trk_flag
);
  logic              tracked;
  logic              evictable;
  logic [CountW-1:0] count;
  stamp_t            hist [MaxK];
  logic              hit;
  logic [KIdxW-1:0]  pick;

  assign hit = (cmd.frame == index);

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked   <= 1'b0;
      evictable <= 1'b0;
      count     <= '0;
    end else if (hit) begin
      if (cmd.access) begin
        tracked <= 1'b1;
        if (!tracked) begin
          evictable <= 1'b0;
          count     <= CountW'(1);
        end else if (count < CountW'(MaxK)) begin
          count <= count + 1'b1;
        end
      end else if (cmd.set_ev && tracked) begin
        evictable <= cmd.ev_value;
      end else if (cmd.forget) begin
        tracked   <= 1'b0;
        evictable <= 1'b0;
        count     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit && cmd.access) begin
      hist[0] <= cmd.stamp;
      for (int i = 1; i < MaxK; i++) hist[i] <= hist[i-1];
    end
  end

  always_comb begin
    view.is_short = ({1'b0, count} < ({1'b0, CountW'(k_sel)} + 1'b1));
    pick = view.is_short ? KIdxW'(count - 1'b1) : k_sel;
    view.key  = hist[pick];
    view.cand = tracked && evictable && (count != '0);
  end

  assign ev_flag  = evictable;
  assign trk_flag = tracked;
endmodule
`default_nettype wire

@@ design/lruk_frame_chain.sv @@
// row of frame cells; views pass cell to cell, one per cycle, to the tail
// depends on lruk_pkg, lruk_cell
`default_nettype none
module lruk_frame_chain import lruk_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [KIdxW-1:0]  k_sel,
  input  wire cell_cmd_t         cmd,
  input  wire logic              load,
  output cell_view_t             tail,
  output logic [FrameW-1:0]      tail_index,
  output logic                   sel_ev,
  output logic                   sel_trk
);
  cell_view_t        views [MaxFrames];
  cell_view_t        pipe  [MaxFrames];
  logic [FrameW-1:0] pidx  [MaxFrames];
  logic [MaxFrames-1:0] evs, trks;

  for (genvar g = 0; g < MaxFrames; g++) begin : g_cell
    lruk_cell u_cell (
      .clk, .rst, .index(FrameW'(g)), .k_sel, .cmd,
      .view(views[g]), .ev_flag(evs[g]), .trk_flag(trks[g])
    );
    // shift register: load snapshots, otherwise each stage passes to its neighbour
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (load) begin
          pipe[g] <= views[g];
          pidx[g] <= FrameW'(g);
        end
      end
    end else begin : g_link
      always_ff @(posedge clk) begin
        if (load) begin
          pipe[g] <= views[g];
          pidx[g] <= FrameW'(g);
        end else begin
          pipe[g] <= pipe[g-1];
          pidx[g] <= pidx[g-1];
        end
      end
    end
  end

  assign tail       = pipe[MaxFrames-1];
  assign tail_index = pidx[MaxFrames-1];
  assign sel_ev     = evs[cmd.frame];
  assign sel_trk    = trks[cmd.frame];
endmodule
`default_nettype wire

@@ test/testbench.sv @@
// self-checking testbench for lru_k_frame_replacer_top: random and directed requests
// depends on lruk_pkg, lruk_if and the replacer rtl
`default_nettype none
module testbench;
  import lruk_pkg::*;

  localparam int StallLimit = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_FRAMES;
  logic [6:0] cfg_data = '0;

  lruk_if #(.T(request_t)) req (.clk(clk));
  lruk_if #(.T(result_t))  rsp (.clk(clk));

  lru_k_frame_replacer_top DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  request_t pending_requests[$];
  result_t  expected_results[$];
  int       mismatches = 0;
  bit       quiet = 1'b0;

  // predictor state
  bit                 tracked_q[MaxFrames];
  bit                 evictable_q[MaxFrames];
  int                 hits_q[MaxFrames];
  stamp_t             stamps_q[MaxFrames][MaxK];
  stamp_t             access_clock_q;
  logic [TotalW-1:0]  evictable_total_q;
  logic [6:0]         frames_in_use_q;
  logic [3:0]         history_depth_q;

  function automatic void forget_frame(int f);
    tracked_q[f] = 0;
    evictable_q[f] = 0;
    hits_q[f] = 0;
    for (int i = 0; i < MaxK; i++) stamps_q[f][i] = '0;
  endfunction

  function automatic result_t predict_result(request_t r);
    result_t res;
    int limit, k, f, best, n;
    bit have, best_short, is_short;
    stamp_t best_stamp, stamp;
    res = '{status: ST_OK, victim_frame: '0, evictable_count: '0};
    limit = frames_in_use_q > MaxFrames ? MaxFrames : int'(frames_in_use_q);
    k = history_depth_q == 0 ? 1 : (history_depth_q > MaxK ? MaxK : int'(history_depth_q));
    f = r.frame;
    case (r.action)
      ACT_ACCESS: begin
        if (f >= limit) res.status = ST_RANGE;
        else begin
          if (access_clock_q != '1) access_clock_q++;
          if (!tracked_q[f]) begin
            tracked_q[f] = 1;
            evictable_q[f] = 0;
            hits_q[f] = 0;
          end
          for (int i = MaxK - 1; i > 0; i--) stamps_q[f][i] = stamps_q[f][i-1];
          stamps_q[f][0] = access_clock_q;
          if (hits_q[f] < MaxK) hits_q[f]++;
        end
      end
      ACT_SET: begin
        if (f >= limit) res.status = ST_RANGE;
        else if (tracked_q[f] && evictable_q[f] != r.make_evictable) begin
          evictable_q[f] = r.make_evictable;
          if (r.make_evictable) evictable_total_q++;
          else evictable_total_q--;
        end
      end
      ACT_REMOVE: begin
        if (tracked_q[f]) begin
          if (!evictable_q[f]) res.status = ST_PINNED;
          else begin
            forget_frame(f);
            evictable_total_q--;
          end
        end
      end
      default: begin
        have = 0; best_short = 0; best_stamp = '0; best = 0;
        for (int g = 0; g < MaxFrames; g++) begin
          n = hits_q[g];
          if (tracked_q[g] && evictable_q[g] && n != 0) begin
            is_short = n < k;
            stamp = is_short ? stamps_q[g][n-1] : stamps_q[g][k-1];
            if (!have || (is_short && !best_short) ||
                (is_short == best_short && stamp < best_stamp)) begin
              have = 1; best_short = is_short; best_stamp = stamp; best = g;
            end
          end
        end
        if (!have) res.status = ST_NONE;
        else begin
          forget_frame(best);
          evictable_total_q--;
          res.victim_frame = FrameW'(best);
        end
      end
    endcase
    res.evictable_count = evictable_total_q;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.data <= '0;
    end else begin
      if (req.valid && req.ready)
        expected_results.insert(expected_results.size(), predict_result(req.data));
      if (!req.valid || req.ready) begin
        if (pending_requests.size() > 0 && (quiet || $urandom_range(99) >= 14)) begin
          req.data <= pending_requests[0];
          pending_requests.delete(0);
          req.valid <= 1'b1;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", rsp.data.status, -1);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (rsp.data.status != want.status)
            report_mismatch("status", rsp.data.status, want.status);
          if (rsp.data.victim_frame != want.victim_frame)
            report_mismatch("victim_frame", rsp.data.victim_frame, want.victim_frame);
          if (rsp.data.evictable_count != want.evictable_count)
            report_mismatch("evictable_count", rsp.data.evictable_count,
                            want.evictable_count);
        end
      end
      rsp.ready <= quiet || $urandom_range(99) >= 14;
    end
  end

  // watchdog
  int stalled_cycles = 0;
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || rst) stalled_cycles <= 0;
    else stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic request_t make_request(action_t a, int f, bit ev);
    request_t r;
    r.action = a;
    r.frame = FrameW'(f);
    r.make_evictable = ev;
    return r;
  endfunction

  function automatic void add_request(action_t a, int f, bit ev);
    pending_requests.insert(pending_requests.size(), make_request(a, f, ev));
  endfunction

  function automatic request_t random_request();
    int pick, f;
    action_t a;
    pick = $urandom_range(99);
    if (pick < 40) a = ACT_ACCESS;
    else if (pick < 65) a = ACT_SET;
    else if (pick < 80) a = ACT_REMOVE;
    else a = ACT_EVICT;
    f = ($urandom_range(9) < 7) ? $urandom_range(15) : $urandom_range(63);
    return make_request(a, f, $urandom_range(99) < 70);
  endfunction

  task automatic write_register(logic index, logic [6:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == CFG_FRAMES) frames_in_use_q = value;
    else history_depth_q = value[3:0];
  endtask

  task automatic drain();
    wait (pending_requests.size() == 0 && expected_results.size() == 0 && !req.valid);
    repeat (80) @(posedge clk);
  endtask

  logic [6:0] frame_settings[7] = '{7'd64, 7'd1, 7'd64, 7'd0, 7'd100, 7'd17, 7'd64};
  logic [6:0] depth_settings[7] = '{7'd2, 7'd1, 7'd8, 7'd0, 7'd15, 7'd3, 7'd2};

  initial begin
    for (int f = 0; f < MaxFrames; f++) forget_frame(f);
    access_clock_q = '0;
    evictable_total_q = '0;
    frames_in_use_q = 7'd64;
    history_depth_q = 4'd2;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed requests at the reset settings
    add_request(ACT_EVICT, 5, 1);
    add_request(ACT_ACCESS, 0, 0);
    add_request(ACT_ACCESS, 63, 1);
    add_request(ACT_ACCESS, 7, 0);
    add_request(ACT_ACCESS, 0, 0);
    add_request(ACT_SET, 9, 1);
    add_request(ACT_REMOVE, 0, 0);
    add_request(ACT_REMOVE, 20, 1);
    add_request(ACT_SET, 0, 1);
    add_request(ACT_SET, 0, 1);
    add_request(ACT_SET, 63, 1);
    add_request(ACT_SET, 7, 1);
    add_request(ACT_EVICT, 0, 0);
    add_request(ACT_SET, 7, 0);
    add_request(ACT_EVICT, 63, 0);
    add_request(ACT_EVICT, 0, 1);
    add_request(ACT_SET, 7, 1);
    add_request(ACT_REMOVE, 7, 0);
    add_request(ACT_ACCESS, 3, 0);
    add_request(ACT_ACCESS, 3, 0);
    add_request(ACT_ACCESS, 4, 0);
    add_request(ACT_ACCESS, 4, 0);
    add_request(ACT_SET, 3, 1);
    add_request(ACT_SET, 4, 1);
    add_request(ACT_EVICT, 0, 0);
    drain();

    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        write_register(CFG_FRAMES, frame_settings[p]);
        write_register(CFG_DEPTH, depth_settings[p]);
      end
      quiet = (p == 2);
      for (int i = 0; i < 290; i++)
        pending_requests.insert(pending_requests.size(), random_request());
      drain();
    end

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire
